>>> sv/qfe_pkg.sv
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared widths, register map and character constants for the query field
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package qfe_pkg;

    localparam int CH_W                  = 8;
    localparam int KEY_W                 = 64;
    localparam int KEY_POS_W             = 4;
    localparam int KEY_IDX_W             = 3;
    localparam int DEFAULT_MAX_KEY_BYTES = 8;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_BYTES  = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_LENGTH = 4'h8;

    localparam logic [CH_W-1:0] CH_NUL = 8'h00;
    localparam logic [CH_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [CH_W-1:0] CH_AMP = 8'h26;

endpackage

`default_nettype wire

>>> sv/query_field_extractor.sv
// ----------------------------------------------------------------------------
// query_field_extractor
// Streaming URL query parameter lookup with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key characters (first character in the lowest byte) at address
//   0x0 and the key length (0..8, larger values saturate) at address 0x8
//   while the block is idle. Then stream the query string one byte per beat
//   on the s_ channel; s_last marks the final byte of each string.
//   The m_ channel returns the value bytes of the first parameter whose name
//   equals the key and is followed by '='. The last beat has m_done_res=1 and
//   holds a byte only if the string ends on a value byte. A string without a
//   match gives one beat with m_found=0 and m_done_res=1. A zero byte ends it.
// Pipeline and throughput:
//   One byte per cycle while the output is not stalled. A byte sits in the
//   input register and its result is loaded into the output register once that
//   register is free. Bytes without a beat still pass through the input
//   register and advance only while the output register is free.
// Reset:
//   aresetn (synchronous, active low) empties both registers, returns the
//   parser to the start of a parameter and clears the key registers.
// Stall:
//   While m_ready is low the output register holds its beat, the input
//   register fills, and s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module query_field_extractor #(
    parameter int MAX_KEY_BYTES = qfe_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [qfe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [qfe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [qfe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,

    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [qfe_pkg::CH_W-1:0]          s_ch,
    input  wire                               s_last,

    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [qfe_pkg::CH_W-1:0]          m_value_byte,
    output logic                              m_has_byte,
    output logic                              m_found,
    output logic                              m_done_res
);
    import qfe_pkg::*;

    localparam logic [1:0] PH_MATCH = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [KEY_POS_W-1:0] MAX_LEN = KEY_POS_W'(MAX_KEY_BYTES);

    logic [KEY_W-1:0]     key_bytes_reg;
    logic [KEY_POS_W-1:0] key_length_reg;

    logic                 in_valid_reg;
    logic [CH_W-1:0]      in_ch_reg;
    logic                 in_last_reg;

    logic [1:0]           phase_reg, phase_next;
    logic [KEY_POS_W-1:0] key_pos_reg, key_pos_next;
    logic                 seen_reg, seen_next;

    logic                 out_valid_reg;
    logic [CH_W-1:0]      out_byte_reg;
    logic                 out_has_reg;
    logic                 out_found_reg;
    logic                 out_done_reg;

    logic                 out_free;
    logic                 advance;
    logic                 cfg_write;
    logic                 emit;
    logic                 has_byte;
    logic [CH_W-1:0]      value_byte;
    logic [1:0]           ph_after;
    logic                 seen_after;
    logic [KEY_POS_W-1:0] eff_len;
    logic [CH_W-1:0]      key_char;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr)
            ADDR_KEY_BYTES:  prdata = key_bytes_reg;
            ADDR_KEY_LENGTH: prdata = CFG_DATA_W'(key_length_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg  <= '0;
            key_length_reg <= '0;
        end else if (cfg_write) begin
            case (paddr)
                ADDR_KEY_BYTES:  key_bytes_reg  <= pwdata;
                ADDR_KEY_LENGTH: key_length_reg <= pwdata[KEY_POS_W-1:0];
                default:         ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_ch_reg   <= s_ch;
            in_last_reg <= s_last;
        end
    end

    assign eff_len  = (key_length_reg > MAX_LEN) ? MAX_LEN : key_length_reg;
    assign key_char = key_bytes_reg[key_pos_reg[KEY_IDX_W-1:0]*CH_W +: CH_W];

    always_comb begin
        emit         = 1'b0;
        has_byte     = 1'b0;
        value_byte   = '0;
        ph_after     = phase_reg;
        key_pos_next = key_pos_reg;
        seen_after   = seen_reg;
        case (phase_reg)
            PH_VALUE: begin
                emit = 1'b1;
                if (in_ch_reg == CH_AMP || in_ch_reg == CH_NUL) begin
                    ph_after = PH_DONE;
                end else begin
                    has_byte   = 1'b1;
                    value_byte = in_ch_reg;
                    if (in_last_reg) begin
                        ph_after = PH_DONE;
                    end
                end
            end
            PH_MATCH, PH_SKIP: begin
                if (in_ch_reg == CH_NUL) begin
                    emit     = 1'b1;
                    ph_after = PH_DONE;
                end else if (in_ch_reg == CH_AMP) begin
                    ph_after     = PH_MATCH;
                    key_pos_next = '0;
                end else if (phase_reg == PH_MATCH) begin
                    if (key_pos_reg < eff_len) begin
                        if (in_ch_reg == key_char) begin
                            key_pos_next = key_pos_reg + 1'b1;
                        end else begin
                            ph_after = PH_SKIP;
                        end
                    end else if (in_ch_reg == CH_EQ) begin
                        ph_after   = PH_VALUE;
                        seen_after = 1'b1;
                    end else begin
                        ph_after = PH_SKIP;
                    end
                end
                if (!emit && in_last_reg) begin
                    emit     = 1'b1;
                    ph_after = PH_DONE;
                end
            end
            default: ;
        endcase
        phase_next = ph_after;
        seen_next  = seen_after;
        if (in_last_reg) begin
            phase_next   = PH_MATCH;
            key_pos_next = '0;
            seen_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MATCH;
            key_pos_reg <= '0;
            seen_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            key_pos_reg <= key_pos_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_byte_reg  <= value_byte;
            out_has_reg   <= has_byte;
            out_found_reg <= seen_after;
            out_done_reg  <= (ph_after == PH_DONE);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_value_byte = out_byte_reg;
    assign m_has_byte   = out_has_reg;
    assign m_found      = out_found_reg;
    assign m_done_res   = out_done_reg;

endmodule

`default_nettype wire

>>> sv/qfe_checker.sv
// ----------------------------------------------------------------------------
// qfe_checker
// Port-level checks for the query field extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qfe_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire [qfe_pkg::CH_W-1:0]  m_value_byte,
    input wire                      m_has_byte,
    input wire                      m_found,
    input wire                      m_done_res
);
    import qfe_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_byte)
            && $stable(m_has_byte) && $stable(m_found) && $stable(m_done_res))
        else $error("result beat changed while stalled");

    a_byte_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> m_found)
        else $error("value byte without a key match");

    a_miss_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_done_res && !m_has_byte)
        else $error("unmatched beat that is not the final one");

    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_value_byte == '0)
        else $error("value byte not zero on a beat without a byte");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind query_field_extractor qfe_checker u_qfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value_byte (m_value_byte),
    .m_has_byte   (m_has_byte),
    .m_found      (m_found),
    .m_done_res   (m_done_res)
);

`default_nettype wire

>>> tb/sv/tb_query_field_extractor.sv
// ----------------------------------------------------------------------------
// tb_query_field_extractor
// Self-checking bench for the streaming query parameter lookup. Query strings
// are fed one byte per beat while a cycle-free model of the parser predicts
// every value beat and end-of-string beat. The key registers are
// reprogrammed over the APB port between phases while the block is idle.
// Both channels idle at random, and the receiver once holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_query_field_extractor;

    import qfe_pkg::*;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES      = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 60;
    localparam int HOLD_AT_BEAT    = 40;
    localparam int IDLE_LIMIT      = 1000;
    localparam int MAX_REPORTS     = 100;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_SKIP,
        SCAN_VALUE,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        logic [CH_W-1:0] value_byte;
        logic            has_byte;
        logic            found;
        logic            done_res;
    } value_beat_t;

    class lookup_checker;
        logic [KEY_W-1:0]     key_chars;
        logic [KEY_POS_W-1:0] key_len;
        scan_t                scan;
        int unsigned          key_pos;
        bit                   matched;
        value_beat_t          beats_due[$];
        int                   errors;

        function new();
            key_chars = '0;
            key_len   = '0;
            scan      = SCAN_MATCH;
            key_pos   = 0;
            matched   = 1'b0;
            errors    = 0;
        endfunction

        function int unsigned key_span();
            return (key_len > DEFAULT_MAX_KEY_BYTES) ? DEFAULT_MAX_KEY_BYTES : key_len;
        endfunction

        // Returns 1 when the byte is parsed, 0 when it falls after the final beat.
        function bit scan_byte(logic [CH_W-1:0] c, logic l);
            bit          emit;
            bit          busy;
            value_beat_t b;
            busy = (scan != SCAN_DONE);
            emit = 1'b0;
            b    = '0;
            case (scan)
                SCAN_VALUE: begin
                    emit = 1'b1;
                    if (c == CH_AMP || c == CH_NUL) begin
                        scan = SCAN_DONE;
                    end else begin
                        b.has_byte   = 1'b1;
                        b.value_byte = c;
                        if (l) scan = SCAN_DONE;
                    end
                end
                SCAN_MATCH, SCAN_SKIP: begin
                    if (c == CH_NUL) begin
                        emit = 1'b1;
                        scan = SCAN_DONE;
                    end else if (c == CH_AMP) begin
                        scan    = SCAN_MATCH;
                        key_pos = 0;
                    end else if (scan == SCAN_MATCH) begin
                        if (key_pos < key_span()) begin
                            if (c == key_chars[key_pos*8 +: 8]) key_pos++;
                            else scan = SCAN_SKIP;
                        end else if (c == CH_EQ) begin
                            scan    = SCAN_VALUE;
                            matched = 1'b1;
                        end else begin
                            scan = SCAN_SKIP;
                        end
                    end
                    if (!emit && l) begin
                        emit = 1'b1;
                        scan = SCAN_DONE;
                    end
                end
                default: ;
            endcase
            if (emit) begin
                b.found    = matched;
                b.done_res = (scan == SCAN_DONE);
                beats_due.push_back(b);
            end
            if (l) begin
                scan    = SCAN_MATCH;
                key_pos = 0;
                matched = 1'b0;
            end
            return busy;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
        endtask

        task match_beat(value_beat_t got);
            value_beat_t exp;
            if (beats_due.size() == 0) begin
                report($sformatf("unexpected beat byte=%02h has=%0b found=%0b done=%0b",
                                 got.value_byte, got.has_byte, got.found, got.done_res));
                return;
            end
            exp = beats_due.pop_front();
            if (got.value_byte !== exp.value_byte)
                report($sformatf("value_byte %02h, want %02h", got.value_byte, exp.value_byte));
            if (got.has_byte !== exp.has_byte)
                report($sformatf("has_byte %0b, want %0b", got.has_byte, exp.has_byte));
            if (got.found !== exp.found)
                report($sformatf("found %0b, want %0b", got.found, exp.found));
            if (got.done_res !== exp.done_res)
                report($sformatf("done_res %0b, want %0b", got.done_res, exp.done_res));
        endtask
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_ch    = '0;
    logic                  s_last  = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CH_W-1:0]       m_value_byte;
    logic                  m_has_byte;
    logic                  m_found;
    logic                  m_done_res;

    lookup_checker   sb = new();
    logic [CH_W-1:0] text_q[$];
    int              parsed_bytes;
    bit              tx_burst;
    bit              rx_hold;
    int              idle_cycles = 0;

    query_field_extractor u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_byte(m_value_byte),
        .m_has_byte  (m_has_byte),
        .m_found     (m_found),
        .m_done_res  (m_done_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = a;
        pwdata  = d;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_key(input logic [KEY_W-1:0] chars, input logic [KEY_POS_W-1:0] len);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[KEY_POS_W-1:0] = len;
        apb_write(ADDR_KEY_BYTES, chars);
        sb.key_chars = chars;
        apb_write(ADDR_KEY_LENGTH, word);
        sb.key_len = len;
    endtask

    // Drop valid, wait for every due beat, then let the pipeline drain.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.beats_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_byte(input logic [CH_W-1:0] c, input logic l);
        int gap;
        gap = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_ch    = c;
        s_last  = l;
        do @(posedge aclk); while (!s_ready);
        if (sb.scan_byte(c, l)) parsed_bytes++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s.getc(i), close && (i == s.len() - 1));
    endtask

    task automatic send_query();
        while (text_q.size() > 1) send_byte(text_q.pop_front(), 1'b0);
        send_byte(text_q.pop_front(), 1'b1);
    endtask

    function automatic logic [CH_W-1:0] pick_char();
        int r;
        int k;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, 7);
        if (r < 6) return 8'($urandom_range(8'h61, 8'h64));
        if (r < 8) return sb.key_chars[k*8 +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_query();
        int n;
        int nparams;
        int kind;
        int cut;
        text_q.delete();
        n = sb.key_span();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            nparams = $urandom_range(1, 4);
            for (int p = 0; p < nparams; p++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    for (int i = 0; i < n; i++) text_q.push_back(sb.key_chars[i*8 +: 8]);
                end else if (kind < 7) begin
                    cut = $urandom_range(0, n);
                    for (int i = 0; i < n; i++)
                        text_q.push_back((i == cut) ? pick_char() : sb.key_chars[i*8 +: 8]);
                    if (cut == n) text_q.push_back(pick_char());
                end else begin
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_char());
                end
                if ($urandom_range(0, 9) != 0) text_q.push_back(CH_EQ);
                repeat ($urandom_range(0, 5)) text_q.push_back(pick_char());
                if (p < nparams - 1 || $urandom_range(0, 7) == 0) text_q.push_back(CH_AMP);
            end
        end
        if (text_q.size() == 0) text_q.push_back(pick_char());
        if ($urandom_range(0, 19) == 0)
            text_q.insert($urandom_range(0, text_q.size() - 1), CH_NUL);
    endtask

    // Receiver: random stalls, bursts of full rate, one long hold-off.
    initial begin : rx_side
        int  w;
        int  beats;
        bit  rx_burst;
        bit  held;
        beats    = 0;
        rx_burst = 1'b0;
        held     = 1'b0;
        rx_hold  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (beats % 32 == 0) rx_burst = ($urandom_range(0, 2) == 0);
            w = rx_burst ? 0 : $urandom_range(0, 6);
            if (!held && beats >= HOLD_AT_BEAT) begin
                w       = HOLD_CYCLES;
                held    = 1'b1;
                rx_hold = 1'b1;
            end
            @(negedge aclk);
            if (w > 0) begin
                m_ready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready = 1'b1;
            rx_hold = 1'b0;
            do @(posedge aclk); while (!m_valid);
            sb.match_beat({m_value_byte, m_has_byte, m_found, m_done_res});
            beats++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : tx_side
        logic [KEY_W-1:0]     chars;
        logic [KEY_POS_W-1:0] len;
        int                   mark;
        parsed_bytes = 0;
        tx_burst     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        load_key(64'hFFFF_FFFF_FFFF_6469, 4'd2);
        send_text("id=", 1'b1);
        send_text("q&id=v&z", 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_text("k", 1'b1);
        send_text("id=b", 1'b1);
        send_text("id=c", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("x", 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int i = 0; i < 8; i++) chars[i*8 +: 8] = 8'($urandom_range(8'h61, 8'h66));
            len = 4'($urandom_range(1, DEFAULT_MAX_KEY_BYTES));
            case (p)
                0: len = 4'd0;
                1: len = 4'd8;
                2: len = 4'd15;
                3: begin chars = '1; len = 4'd8; end
                4: begin chars = '0; len = 4'd3; end
                5: begin chars[15:8] = CH_AMP; len = 4'd3; end
                default: ;
            endcase
            settle();
            load_key(chars, len);
            mark = parsed_bytes;
            while (parsed_bytes - mark < ITEMS_PER_PHASE) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                build_query();
                send_query();
            end
        end

        settle();
        if (m_valid) sb.report("beat left on the result channel");
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
